// ===== design/tlf_pkg.sv =====
// Shared types and constants for the TLB with LRU or FIFO replacement.
// Holds the beat structs, the command passed from front to back, and defaults.
// No dependencies.
`default_nettype none

package tlf_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_PAGE_BITS  = 16;
  localparam int DEF_FRAME_BITS = 16;
  localparam int DEF_AGE_BITS   = 16;
  localparam int FLUSH_AGE      = 10000;
  localparam int Q_DEPTH        = 2;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_TOUCH  = 2'd1;
  localparam logic [1:0] FUNC_FILL   = 2'd2;
  localparam logic [1:0] FUNC_FLUSH  = 2'd3;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] page;
    logic [15:0] frame_in;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] frame_out;
    logic [3:0]  victim_index;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_LOOKUP    = 3'd0,
    OP_TOUCH     = 3'd1,
    OP_FILL_LRU  = 3'd2,
    OP_FILL_FIFO = 3'd3,
    OP_FLUSH     = 3'd4
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] page;
    logic [15:0] frame;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_out_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } bk_stat_t;

endpackage

`default_nettype wire

// ===== design/tlb_lru_fifo.sv =====
// Top level of the fully associative TLB with LRU or FIFO replacement.
// Instantiates tlf_front and tlf_back; depends on tlf_pkg.
//
//   Port group  Dir  Handshake          Beat
//   in_*        in   in_valid/in_stall   in_item_t (func, page, frame_in)
//   out_*       out  out_valid/out_stall out_item_t (hit, frame_out, victim_index)
//   cfg_*       in   cfg_valid/cfg_ready replace_policy bit
//
// Lookup, touch and LRU fill scan every entry in the back end, reading one entry per cycle
// from the single read port of the memories. FIFO fill and flush do not scan.
// A two-beat queue sits in front of the scan.
// Reset is synchronous: all entries become invalid with the flush age, pointer zero.
// A result waits in the output register while the queue keeps taking beats.
`default_nettype none

module tlb_lru_fifo
  import tlf_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int PAGE_BITS  = DEF_PAGE_BITS,
  parameter int FRAME_BITS = DEF_FRAME_BITS,
  parameter int AGE_BITS   = DEF_AGE_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  logic     policy_r;
  q_out_t   q_out;
  bk_stat_t bk_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_LRU;
    end else if (cfg_valid && cfg_ready) begin
      policy_r <= cfg_data;
    end
  end

  tlf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .policy   (policy_r),
    .bk_stat  (bk_stat),
    .q_out    (q_out)
  );

  tlf_back #(
    .ENTRIES    (ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS),
    .AGE_BITS   (AGE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_out     (q_out),
    .bk_stat   (bk_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_pop_needs_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> q_out.valid)
    else $error("back end popped an empty queue");

  a_accept_queues : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> q_out.valid)
    else $error("accepted beat did not reach the queue");

  a_result_from_work : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_stat.busy))
    else $error("result appeared without back-end work");

endmodule

`default_nettype wire

// ===== design/tlf_front.sv =====
// Front end: accepts input beats, classifies the operation, and queues commands.
// Depends on tlf_pkg.
`default_nettype none

module tlf_front
  import tlf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     policy,
  input  wire bk_stat_t bk_stat,
  output q_out_t        q_out
);

  cmd_t       q_r [Q_DEPTH];
  logic [0:0] wptr_r, wptr_nxt;
  logic [0:0] rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.page  = in_data.page;
    cmd_in.frame = in_data.frame_in;
    unique case (in_data.func)
      FUNC_LOOKUP: cmd_in.op = OP_LOOKUP;
      FUNC_TOUCH:  cmd_in.op = OP_TOUCH;
      FUNC_FILL:   cmd_in.op = (policy == POLICY_FIFO) ? OP_FILL_FIFO : OP_FILL_LRU;
      FUNC_FLUSH:  cmd_in.op = OP_FLUSH;
    endcase
  end

  assign in_stall    = (cnt_r == 2'(Q_DEPTH));
  assign push        = in_valid && !in_stall;
  assign pop         = bk_stat.pop && (cnt_r != 2'd0);
  assign q_out.valid = (cnt_r != 2'd0);
  assign q_out.cmd   = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/tlf_back.sv =====
// Back end: entry memories, valid and age-reset flags, the scan sequencer and the
// output register. Depends on tlf_pkg.
`default_nettype none

module tlf_back
  import tlf_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int PAGE_BITS  = DEF_PAGE_BITS,
  parameter int FRAME_BITS = DEF_FRAME_BITS,
  parameter int AGE_BITS   = DEF_AGE_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire q_out_t q_out,
  output bk_stat_t    bk_stat,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_item_t   out_data
);

  localparam int IDXW = $clog2(ENTRIES);
  localparam int ENTW = PAGE_BITS + FRAME_BITS;
  localparam logic [AGE_BITS-1:0] AGE_FLUSH = AGE_BITS'(FLUSH_AGE);
  localparam logic [AGE_BITS-1:0] AGE_MAX   = '1;
  localparam logic [IDXW-1:0]     LAST_IDX  = IDXW'(ENTRIES - 1);
  localparam logic [IDXW:0]       ISS_END   = (IDXW + 1)'(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  logic [ENTW-1:0]     ent_mem_r [ENTRIES];
  logic [AGE_BITS-1:0] age_mem_r [ENTRIES];
  logic [ENTW-1:0]     ent_rd_r;
  logic [AGE_BITS-1:0] age_rd_r;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [PAGE_BITS-1:0]  pg_r, pg_nxt;
  logic [FRAME_BITS-1:0] fr_r, fr_nxt;
  logic [IDXW:0]         iss_r, iss_nxt;
  logic                  dv_r, dv_nxt;
  logic [IDXW-1:0]       didx_r, didx_nxt;
  logic                  hit_r, hit_nxt;
  logic [FRAME_BITS-1:0] fout_r, fout_nxt;
  logic [AGE_BITS-1:0]   best_age_r, best_age_nxt;
  logic [IDXW-1:0]       best_idx_r, best_idx_nxt;
  logic [IDXW-1:0]       slot_r, slot_nxt;
  logic [IDXW-1:0]       ptr_r, ptr_nxt;
  logic [ENTRIES-1:0]    valid_r, valid_nxt;
  logic [ENTRIES-1:0]    init_r, init_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  ent_we;
  logic [ENTW-1:0]       ent_wdata;
  logic                  age_we;
  logic [IDXW-1:0]       age_waddr;
  logic [AGE_BITS-1:0]   age_wdata;
  logic [IDXW-1:0]       rd_addr;
  logic [PAGE_BITS-1:0]  rd_pg;
  logic [FRAME_BITS-1:0] rd_fr;
  logic                  match;
  logic [AGE_BITS-1:0]   cur_age;
  logic [AGE_BITS-1:0]   t_age;
  logic                  pop;
  logic                  out_free;

  assign rd_addr  = iss_r[IDXW-1:0];
  assign rd_pg    = ent_rd_r[ENTW-1 -: PAGE_BITS];
  assign rd_fr    = ent_rd_r[FRAME_BITS-1:0];
  assign match    = valid_r[didx_r] && (rd_pg == pg_r);
  assign cur_age  = init_r[didx_r] ? AGE_FLUSH : age_rd_r;
  assign t_age    = match ? '0 : cur_age;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem_r[slot_r] <= ent_wdata;
    end
    ent_rd_r <= ent_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem_r[age_waddr] <= age_wdata;
    end
    age_rd_r <= age_mem_r[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pg_nxt        = pg_r;
    fr_nxt        = fr_r;
    iss_nxt       = iss_r;
    dv_nxt        = 1'b0;
    didx_nxt      = didx_r;
    hit_nxt       = hit_r;
    fout_nxt      = fout_r;
    best_age_nxt  = best_age_r;
    best_idx_nxt  = best_idx_r;
    slot_nxt      = slot_r;
    ptr_nxt       = ptr_r;
    valid_nxt     = valid_r;
    init_nxt      = init_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ent_we        = 1'b0;
    ent_wdata     = {pg_r, fr_r};
    age_we        = 1'b0;
    age_waddr     = didx_r;
    age_wdata     = '0;
    pop           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_out.valid) begin
          pop          = 1'b1;
          op_nxt       = q_out.cmd.op;
          pg_nxt       = PAGE_BITS'(q_out.cmd.page);
          fr_nxt       = FRAME_BITS'(q_out.cmd.frame);
          hit_nxt      = 1'b0;
          fout_nxt     = '0;
          slot_nxt     = '0;
          iss_nxt      = '0;
          best_age_nxt = '0;
          best_idx_nxt = '0;
          priority case (q_out.cmd.op)
            OP_FLUSH: begin
              valid_nxt = '0;
              init_nxt  = '1;
              state_nxt = S_DONE;
            end
            OP_FILL_FIFO: begin
              slot_nxt  = ptr_r;
              ptr_nxt   = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
              state_nxt = S_WRITE;
            end
            default: begin
              state_nxt = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (iss_r < ISS_END) begin
          dv_nxt   = 1'b1;
          didx_nxt = rd_addr;
          iss_nxt  = iss_r + 1'b1;
        end
        if (dv_r) begin
          unique case (op_r)
            OP_LOOKUP: begin
              if (match) begin
                hit_nxt  = 1'b1;
                fout_nxt = rd_fr;
              end
            end
            OP_TOUCH: begin
              age_we             = 1'b1;
              age_wdata          = (t_age != AGE_MAX) ? t_age + 1'b1 : t_age;
              init_nxt[didx_r]   = 1'b0;
            end
            OP_FILL_LRU: begin
              if (cur_age > best_age_r) begin
                best_age_nxt = cur_age;
                best_idx_nxt = didx_r;
              end
            end
            default: begin
            end
          endcase
          if (didx_r == LAST_IDX) begin
            dv_nxt = 1'b0;
            if (op_r == OP_FILL_LRU) begin
              slot_nxt  = best_idx_nxt;
              state_nxt = S_WRITE;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_WRITE: begin
        ent_we            = 1'b1;
        age_we            = 1'b1;
        age_waddr         = slot_r;
        age_wdata         = '0;
        valid_nxt[slot_r] = 1'b1;
        init_nxt[slot_r]  = 1'b0;
        state_nxt         = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.hit          = hit_r;
          out_data_nxt.frame_out    = 16'(fout_r);
          out_data_nxt.victim_index = 4'(slot_r);
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pg_r       <= pg_nxt;
    fr_r       <= fr_nxt;
    iss_r      <= iss_nxt;
    didx_r     <= didx_nxt;
    hit_r      <= hit_nxt;
    fout_r     <= fout_nxt;
    best_age_r <= best_age_nxt;
    best_idx_r <= best_idx_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dv_r        <= 1'b0;
      ptr_r       <= '0;
      valid_r     <= '0;
      init_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      ptr_r       <= ptr_nxt;
      valid_r     <= valid_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign bk_stat.pop  = pop;
  assign bk_stat.busy = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for tlb_lru_fifo: a directed table followed by random traffic.
// Checks every result beat field by field against its own copy of the TLB state, or the table's value for fixed rows.
// Depends on tlf_pkg and the tlb_lru_fifo RTL.
module testbench;
  import tlf_pkg::*;

  localparam int          N_SLOTS      = 16;
  localparam logic [15:0] AGE_MAX      = 16'hFFFF;
  localparam int          STALL_LIMIT  = 5000;
  localparam int          PHASE_ITEMS  = 106;
  localparam int          POOL_SIZE    = 24;
  localparam int          TAIL_CYCLES  = 40;

  typedef struct packed {
    in_item_t  item;
    logic      policy;
    logic      fixed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  logic [15:0] tlb_page [N_SLOTS];
  logic [15:0] tlb_frame [N_SLOTS];
  logic [15:0] tlb_age [N_SLOTS];
  logic        tlb_valid [N_SLOTS];
  logic [3:0]  fifo_ptr;
  logic        repl_policy;

  out_item_t   pending_results [$];
  dir_row_t    dir_rows [$];
  logic [15:0] page_pool [POOL_SIZE];
  int          in_idle_pct;
  int          out_stall_pct;
  int          errors;
  int          quiet_cycles = 0;

  tlb_lru_fifo u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic out_item_t predict_translation(input in_item_t it);
    out_item_t   r;
    logic [15:0] oldest;
    logic [3:0]  slot;
    r = '0;
    unique case (it.func)
      FUNC_LOOKUP: begin
        for (int k = 0; k < N_SLOTS; k++) begin
          if (tlb_valid[k] && tlb_page[k] == it.page) begin
            r.hit = 1'b1;
            r.frame_out = tlb_frame[k];
          end
        end
      end
      FUNC_TOUCH: begin
        for (int k = 0; k < N_SLOTS; k++) begin
          if (tlb_valid[k] && tlb_page[k] == it.page) tlb_age[k] = '0;
          if (tlb_age[k] != AGE_MAX) tlb_age[k] = tlb_age[k] + 16'd1;
        end
      end
      FUNC_FILL: begin
        if (repl_policy == POLICY_LRU) begin
          slot = '0;
          oldest = '0;
          for (int k = 0; k < N_SLOTS; k++) begin
            if (tlb_age[k] > oldest) begin
              oldest = tlb_age[k];
              slot = 4'(k);
            end
          end
        end else begin
          slot = fifo_ptr;
          fifo_ptr = fifo_ptr + 4'd1;
        end
        tlb_page[slot] = it.page;
        tlb_frame[slot] = it.frame_in;
        tlb_valid[slot] = 1'b1;
        tlb_age[slot] = '0;
        r.victim_index = slot;
      end
      default: begin
        for (int k = 0; k < N_SLOTS; k++) begin
          tlb_valid[k] = 1'b0;
          tlb_age[k] = 16'(FLUSH_AGE);
        end
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 35) it.func = FUNC_LOOKUP;
    else if (pick < 60) it.func = FUNC_TOUCH;
    else if (pick < 97) it.func = FUNC_FILL;
    else it.func = FUNC_FLUSH;
    if ($urandom_range(99) < 80) it.page = page_pool[$urandom_range(POOL_SIZE - 1)];
    else it.page = 16'($urandom);
    it.frame_in = 16'($urandom);
    return it;
  endfunction

  task automatic add_row(input logic [1:0] func, input logic [15:0] page,
                         input logic [15:0] frame, input logic policy, input logic fixed,
                         input logic hit, input logic [15:0] fout, input logic [3:0] victim);
    dir_row_t row;
    row.item = '{func: func, page: page, frame_in: frame};
    row.policy = policy;
    row.fixed = fixed;
    row.want = '{hit: hit, frame_out: fout, victim_index: victim};
    dir_rows.push_back(row);
  endtask

  task automatic send_beat(input in_item_t it, input logic fixed, input out_item_t want);
    out_item_t guess;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = predict_translation(it);
    pending_results.push_back(fixed ? want : guess);
    @(negedge clk);
  endtask

  task automatic write_policy(input logic policy);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= policy;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    repl_policy = policy;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result beat: hit=%0d frame=%h victim=%0d",
                   out_data.hit, out_data.frame_out, out_data.victim_index);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data.hit !== want.hit || out_data.frame_out !== want.frame_out ||
            out_data.victim_index !== want.victim_index) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp hit=%0d frame=%h victim=%0d act hit=%0d frame=%h victim=%0d",
                     want.hit, want.frame_out, want.victim_index,
                     out_data.hit, out_data.frame_out, out_data.victim_index);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    errors = 0;
    for (int k = 0; k < N_SLOTS; k++) begin
      tlb_page[k] = '0;
      tlb_frame[k] = '0;
      tlb_valid[k] = 1'b0;
      tlb_age[k] = 16'(FLUSH_AGE);
    end
    fifo_ptr = '0;
    repl_policy = POLICY_LRU;
    page_pool[0] = 16'h0000;
    page_pool[1] = 16'hFFFF;
    for (int k = 2; k < POOL_SIZE; k++) page_pool[k] = 16'($urandom);

    add_row(FUNC_LOOKUP, 16'h0000, 16'h0000, POLICY_LRU,  1'b1, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_FILL,   16'h0000, 16'hFFFF, POLICY_LRU,  1'b1, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_FILL,   16'hFFFF, 16'h0000, POLICY_LRU,  1'b1, 1'b0, 16'h0000, 4'd1);
    add_row(FUNC_LOOKUP, 16'hFFFF, 16'h1234, POLICY_LRU,  1'b1, 1'b1, 16'h0000, 4'd0);
    add_row(FUNC_LOOKUP, 16'h0000, 16'h0000, POLICY_LRU,  1'b1, 1'b1, 16'hFFFF, 4'd0);
    add_row(FUNC_TOUCH,  16'h0000, 16'hFFFF, POLICY_LRU,  1'b0, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_FILL,   16'h1234, 16'hABCD, POLICY_LRU,  1'b1, 1'b0, 16'h0000, 4'd2);
    add_row(FUNC_FILL,   16'h1234, 16'h5555, POLICY_LRU,  1'b0, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_LOOKUP, 16'h1234, 16'h0000, POLICY_LRU,  1'b1, 1'b1, 16'h5555, 4'd0);
    add_row(FUNC_LOOKUP, 16'h8000, 16'h0000, POLICY_LRU,  1'b1, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_TOUCH,  16'h1234, 16'h0000, POLICY_LRU,  1'b0, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_FLUSH,  16'hFFFF, 16'hFFFF, POLICY_LRU,  1'b1, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_LOOKUP, 16'hFFFF, 16'h0000, POLICY_LRU,  1'b1, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_TOUCH,  16'hFFFF, 16'h0000, POLICY_LRU,  1'b0, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_FILL,   16'hAAAA, 16'h5555, POLICY_LRU,  1'b0, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_LOOKUP, 16'hAAAA, 16'h0000, POLICY_LRU,  1'b0, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_FILL,   16'h5555, 16'hAAAA, POLICY_FIFO, 1'b1, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_FILL,   16'h00FF, 16'hFF00, POLICY_FIFO, 1'b1, 1'b0, 16'h0000, 4'd1);
    add_row(FUNC_LOOKUP, 16'h5555, 16'h0000, POLICY_FIFO, 1'b1, 1'b1, 16'hAAAA, 4'd0);
    add_row(FUNC_FLUSH,  16'h0000, 16'h0000, POLICY_FIFO, 1'b1, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_FILL,   16'hF0F0, 16'h0F0F, POLICY_FIFO, 1'b1, 1'b0, 16'h0000, 4'd2);
    add_row(FUNC_FILL,   16'h0F0F, 16'hF0F0, POLICY_LRU,  1'b0, 1'b0, 16'h0000, 4'd0);
    add_row(FUNC_TOUCH,  16'h0F0F, 16'h0000, POLICY_LRU,  1'b0, 1'b0, 16'h0000, 4'd0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_policy(POLICY_LRU);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].policy != repl_policy) write_policy(dir_rows[i].policy);
      send_beat(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      for (int half = 0; half < 2; half++) begin
        write_policy((phase + half) % 2 == 0 ? POLICY_FIFO : POLICY_LRU);
        in_idle_pct = (phase == 1) ? 65 : (phase == 3) ? 34 : 0;
        out_stall_pct = (phase == 2) ? 65 : (phase == 3) ? 34 : 0;
        for (int n = 0; n < PHASE_ITEMS; n++) send_beat(random_item(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
